[rtl/core/ptcf_pkg.sv]
// Shared types and constants of the pad/time cluster finder.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package ptcf_pkg;

    // field widths
    localparam int ROW_W   = 8;
    localparam int PAD_W   = 8;
    localparam int TIME_W  = 10;
    localparam int ADC_W   = 10;
    localparam int CHG_W   = 24;
    localparam int PSUM_W  = 32;
    localparam int TSUM_W  = 40;
    localparam int SQ_W    = 48;
    localparam int MRG_W   = 8;
    localparam int CNT_W   = 16;
    localparam int MEAN_W  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // sequence accumulator widths, sized for the longest allowed sequence
    localparam int TC_W    = 20;
    localparam int MT_W    = 30;
    localparam int ST_W    = 40;
    localparam int PP_W    = TC_W + PAD_W;
    localparam int PADSQ_W = 2 * PAD_W;
    localparam int PSQ_W   = TC_W + PADSQ_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MERGES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_DECONV  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_DECONV   = 3'd4;

    // item codes
    localparam logic MODE_SAMPLE    = 1'b0;
    localparam logic MODE_EVENT_END = 1'b1;
    localparam logic KIND_CLUSTER   = 1'b0;
    localparam logic KIND_END       = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ROW_W-1:0]  row;
        logic [PAD_W-1:0]  pad;
        logic [TIME_W-1:0] time_bin;
        logic [ADC_W-1:0]  charge;
        logic              seq_end;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [ROW_W-1:0]  cluster_row;
        logic [CHG_W-1:0]  total_charge;
        logic [PSUM_W-1:0] pad_sum;
        logic [TSUM_W-1:0] time_sum;
        logic [SQ_W-1:0]   pad_sq_sum;
        logic [SQ_W-1:0]   time_sq_sum;
        logic [MRG_W-1:0]  merge_count;
        logic [CNT_W-1:0]  cluster_count;
        logic              last;
    } out_item_t;

    // one completed time sequence
    typedef struct packed {
        logic [TC_W-1:0]          tc;
        logic [MT_W-1:0]          mt;
        logic [ST_W-1:0]          st;
        logic signed [MEAN_W-1:0] mean;
        logic [ROW_W-1:0]         row;
        logic [PAD_W-1:0]         pad;
    } seq_t;

    // one cluster slot word
    typedef struct packed {
        logic [ROW_W-1:0]         row;
        logic [MRG_W-1:0]         merges;
        logic [CHG_W-1:0]         charge;
        logic signed [MEAN_W-1:0] mean;
        logic [CHG_W-1:0]         last_charge;
        logic                     falling;
        logic [PSUM_W-1:0]        pad_sum;
        logic [TSUM_W-1:0]        time_sum;
        logic [SQ_W-1:0]          pad_sq_sum;
        logic [SQ_W-1:0]          time_sq_sum;
    } slot_t;

    // sequence unit results toward the controller
    typedef struct packed {
        logic done;
        logic split;
        logic fin;
    } seq_status_t;

endpackage

`default_nettype wire

[rtl/core/ptcf_seq_acc.sv]
// Time sequence tracker: sums charge, time*charge and time^2*charge per sequence.
// Depends on ptcf_pkg; captures split and end snapshots for the controller.
`default_nettype none

module ptcf_seq_acc import ptcf_pkg::*; #(
    parameter int MAX_SEQ_LEN = 255
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              sample_en,
    input  wire logic              flush_en,
    input  wire logic [ROW_W-1:0]  row,
    input  wire logic [PAD_W-1:0]  pad,
    input  wire logic [TIME_W-1:0] time_bin,
    input  wire logic [ADC_W-1:0]  charge,
    input  wire logic              seq_end,
    input  wire logic              time_deconv_on,
    output seq_status_t            status,
    output seq_t                   split_snap,
    output seq_t                   end_snap
);

    localparam int LEN_W = $clog2(MAX_SEQ_LEN + 1);
    localparam int P_W   = TIME_W + ADC_W;
    localparam int TT_W  = 2 * TIME_W;

    logic [LEN_W-1:0]  len_reg, total_reg;
    logic [TIME_W-1:0] start_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [PAD_W-1:0]  pad_reg;
    logic [ADC_W-1:0]  last_reg;
    logic              falling_reg;
    logic [TC_W-1:0]   acc_tc_reg;
    logic [MT_W-1:0]   acc_mt_reg;
    logic [ST_W-1:0]   acc_st_reg;

    logic              s1_reg, s2_reg, fin1_reg, fin2_reg, split1_reg, split2_reg;
    logic [P_W-1:0]    tcp_reg;
    logic [TT_W-1:0]   tt_reg;
    logic [ADC_W-1:0]  c1_reg;
    logic [MT_W-1:0]   stp_reg;
    seq_status_t       status_reg;
    seq_t              split_snap_reg, end_snap_reg;

    logic              fresh, e_falling, split_now;
    logic [TIME_W-1:0] e_start;
    logic [LEN_W-1:0]  e_len, e_total;
    logic [ADC_W-1:0]  e_last;
    logic [ROW_W-1:0]  e_row;
    logic [PAD_W-1:0]  e_pad;
    logic [LEN_W:0]    total_inc;
    logic [ST_W-1:0]   st_total;

    function automatic logic signed [MEAN_W-1:0] mean_of(input logic [TIME_W-1:0] s,
                                                         input logic [LEN_W-1:0] l);
        mean_of = $signed(MEAN_W'(s)) - $signed(MEAN_W'(l >> 1));
    endfunction

    // effective tracking state for the incoming sample
    always_comb begin
        fresh     = (total_reg == '0);
        e_start   = fresh ? time_bin : start_reg;
        e_len     = fresh ? '0 : len_reg;
        e_total   = fresh ? '0 : total_reg;
        e_last    = fresh ? '0 : last_reg;
        e_falling = fresh ? 1'b0 : falling_reg;
        e_row     = fresh ? row : row_reg;
        e_pad     = fresh ? pad : pad_reg;
        split_now = time_deconv_on && e_falling && (charge > e_last);
        total_inc = (LEN_W+1)'(e_total) + 1'b1;
        st_total  = acc_st_reg + ST_W'(stp_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            total_reg   <= '0;
            last_reg    <= '0;
            falling_reg <= 1'b0;
            acc_tc_reg  <= '0;
            acc_mt_reg  <= '0;
            acc_st_reg  <= '0;
            s1_reg      <= 1'b0;
            s2_reg      <= 1'b0;
            status_reg  <= '0;
        end else begin
            status_reg <= '0;
            s1_reg     <= 1'b0;
            s2_reg     <= s1_reg;
            // stage 1: split decision and products
            if (sample_en) begin
                if (split_now) begin
                    split_snap_reg <= '{tc: acc_tc_reg, mt: acc_mt_reg, st: acc_st_reg,
                                        mean: mean_of(e_start, e_len),
                                        row: e_row, pad: e_pad};
                    acc_tc_reg  <= '0;
                    acc_mt_reg  <= '0;
                    acc_st_reg  <= '0;
                    start_reg   <= time_bin;
                    len_reg     <= LEN_W'(1);
                    falling_reg <= 1'b0;
                end else begin
                    start_reg   <= e_start;
                    len_reg     <= e_len + 1'b1;
                    falling_reg <= e_falling | (charge < e_last);
                end
                total_reg  <= total_inc[LEN_W-1:0];
                last_reg   <= charge;
                row_reg    <= e_row;
                pad_reg    <= e_pad;
                fin1_reg   <= seq_end || (total_inc >= (LEN_W+1)'(MAX_SEQ_LEN));
                split1_reg <= split_now;
                tcp_reg    <= P_W'(time_bin) * P_W'(charge);
                tt_reg     <= TT_W'(time_bin) * TT_W'(time_bin);
                c1_reg     <= charge;
                s1_reg     <= 1'b1;
            end
            // stage 2: charge and first moment
            if (s1_reg) begin
                acc_tc_reg <= acc_tc_reg + TC_W'(c1_reg);
                acc_mt_reg <= acc_mt_reg + MT_W'(tcp_reg);
                stp_reg    <= MT_W'(tt_reg) * MT_W'(c1_reg);
                fin2_reg   <= fin1_reg;
                split2_reg <= split1_reg;
            end
            // stage 3: second moment, close the sequence on its end
            if (s2_reg) begin
                if (fin2_reg) begin
                    end_snap_reg <= '{tc: acc_tc_reg, mt: acc_mt_reg, st: st_total,
                                      mean: mean_of(start_reg, len_reg),
                                      row: row_reg, pad: pad_reg};
                    acc_tc_reg  <= '0;
                    acc_mt_reg  <= '0;
                    acc_st_reg  <= '0;
                    len_reg     <= '0;
                    total_reg   <= '0;
                    last_reg    <= '0;
                    falling_reg <= 1'b0;
                end else begin
                    acc_st_reg <= st_total;
                end
                status_reg <= '{done: 1'b1, split: split2_reg, fin: fin2_reg};
            end
            // end of event: close whatever is open and clear tracking
            if (flush_en) begin
                end_snap_reg <= '{tc: acc_tc_reg, mt: acc_mt_reg, st: acc_st_reg,
                                  mean: mean_of(start_reg, len_reg),
                                  row: row_reg, pad: pad_reg};
                acc_tc_reg  <= '0;
                acc_mt_reg  <= '0;
                acc_st_reg  <= '0;
                len_reg     <= '0;
                total_reg   <= '0;
                last_reg    <= '0;
                falling_reg <= 1'b0;
                status_reg  <= '{done: 1'b1, split: 1'b0, fin: (total_reg != '0)};
            end
        end
    end

    assign status     = status_reg;
    assign split_snap = split_snap_reg;
    assign end_snap   = end_snap_reg;

endmodule

`default_nettype wire

[rtl/core/ptcf_slot_mem.sv]
// Cluster slot memory with per-slot busy flags; a free slot reads as zero.
// Depends on ptcf_pkg for the slot word type.
`default_nettype none

module ptcf_slot_mem import ptcf_pkg::*; #(
    parameter int SLOTS = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
    output slot_t                         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
    input  slot_t                         wr_data,
    input  wire logic                     free_en,
    input  wire logic [$clog2(SLOTS)-1:0] free_addr,
    input  wire logic                     clear_all,
    output logic [SLOTS-1:0]              busy
);

    slot_t              mem [SLOTS];
    slot_t              q_reg;
    logic               q_busy_reg;
    logic [SLOTS-1:0]   busy_reg;

    // storage and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    // busy flags, a slot holds a cluster exactly while its flag is set
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= '0;
            q_busy_reg <= 1'b0;
        end else begin
            if (rd_en) begin
                q_busy_reg <= busy_reg[rd_addr];
            end
            if (clear_all) begin
                busy_reg <= '0;
            end else begin
                if (wr_en) begin
                    busy_reg[wr_addr] <= 1'b1;
                end
                if (free_en) begin
                    busy_reg[free_addr] <= 1'b0;
                end
            end
        end
    end

    assign rd_data = q_busy_reg ? q_reg : '0;
    assign busy    = busy_reg;

endmodule

`default_nettype wire

[rtl/core/ptcf_list_mem.sv]
// Slot pointer list: a ring of slot indexes with per-entry valid flags.
// Depends on ptcf_pkg only through the house import.
`default_nettype none

module ptcf_list_mem import ptcf_pkg::*; #(
    parameter int DEPTH  = 32,
    parameter int SLOT_W = 5
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic                          rd_valid,
    output logic [SLOT_W-1:0]             rd_slot,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [SLOT_W-1:0]        wr_slot,
    input  wire logic                     inv_en,
    input  wire logic [$clog2(DEPTH)-1:0] inv_addr,
    input  wire logic                     clear_all
);

    logic [SLOT_W-1:0] mem [DEPTH];
    logic [SLOT_W-1:0] q_reg;
    logic              q_valid_reg;
    logic [DEPTH-1:0]  valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_slot;
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    // valid flags, invalidate wins over a write to the same entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end else begin
            if (rd_en) begin
                q_valid_reg <= valid_reg[rd_addr];
            end
            if (clear_all) begin
                valid_reg <= '0;
            end else begin
                if (wr_en) begin
                    valid_reg[wr_addr] <= 1'b1;
                end
                if (inv_en) begin
                    valid_reg[inv_addr] <= 1'b0;
                end
            end
        end
    end

    assign rd_valid = q_valid_reg;
    assign rd_slot  = q_reg;

endmodule

`default_nettype wire

[rtl/core/pad_time_cluster_finder_unit.sv]
// Top level of the pad/time cluster finder: controller, output staging, config.
// Depends on ptcf_pkg, ptcf_seq_acc, ptcf_slot_mem and ptcf_list_mem.
`default_nettype none

// Samples are taken one at a time, ordered by row, pad and falling time. A
// sample passes through the split, first-moment and second-moment stages of
// the sequence accumulator. When it closes a sequence (or a split), the
// controller forms the pad products, sets up the previous pad's window,
// reads the pointer-list entries of that window and their slots, scans up to
// CLUSTER_SLOTS slots for a free one when a new cluster opens, and retires
// one list entry. An end-of-event item retires every open list entry and
// then emits the end marker. Results wait in a staging register and an
// output register, so a slow consumer stalls only the cycle that needs to
// emit. No clearing pass is needed after reset: slot and list entries
// carry valid flags.
module pad_time_cluster_finder_unit import ptcf_pkg::*; #(
    parameter int CLUSTER_SLOTS = 32,
    parameter int LIST_DEPTH    = 32,
    parameter int MAX_SEQ_LEN   = 255
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  in_item_t                   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SL_W = $clog2(CLUSTER_SLOTS);
    localparam int LP_W = $clog2(LIST_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE, ST_ACC_WAIT, ST_PICK, ST_MUL1, ST_MUL2, ST_PSTART,
        ST_WALK, ST_WALK_L, ST_WALK_S, ST_INS, ST_OSTEP, ST_OUT_L, ST_OUT_S,
        ST_EV_DRAIN, ST_EV_MARK, ST_EV_CLR, ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [7:0]       mw_reg;
    logic [CHG_W-1:0] thr_reg;
    logic [MRG_W-1:0] minm_reg;
    logic             tdc_reg, pdc_reg;

    // controller registers
    logic             ev_reg, split_p_reg, fin_p_reg, step_out_reg;
    seq_t             cur_reg;
    logic [PP_W-1:0]    pprod_reg;
    logic [PADSQ_W-1:0] padsq_reg;
    logic [PSQ_W-1:0]   psq_reg;
    logic [LP_W-1:0]  wp_reg, rp_reg, ep_reg, fp_reg, op_reg;
    logic [SL_W-1:0]  alloc_reg, cand_reg, cnt_reg, idx_reg;
    logic [ROW_W-1:0] prev_row_reg;
    logic [PAD_W-1:0] prev_pad_reg;
    logic [CNT_W-1:0] count_reg;
    out_item_t        pend_reg, out_reg;
    logic             pend_v_reg, out_v_reg;

    // sequence unit
    seq_status_t acc_st;
    seq_t        split_snap, end_snap;
    logic        acc_sample_en, acc_flush_en, in_acc;

    // memory ports
    slot_t             slot_q, slot_wr_data, merged_slot, ins_slot;
    logic              slot_rd_en, slot_wr_en, slot_free_en, slot_clear;
    logic [SL_W-1:0]   slot_rd_addr, slot_wr_addr;
    logic [CLUSTER_SLOTS-1:0] busy;
    logic              lst_rd_en, lst_wr_en, lst_inv_en, lst_clear;
    logic              lst_q_valid;
    logic [SL_W-1:0]   lst_q_slot, lst_wr_slot;
    logic [LP_W-1:0]   lst_rd_addr, lst_wr_addr, lst_inv_addr;

    // decision terms
    logic signed [MEAN_W:0] diff, mw_s;
    logic             too_late, too_early, rising, refuse, merge_go, qual;
    logic             out_free, can_emit;
    out_item_t        cluster_item, marker_item;
    logic [CHG_W:0]   chg_add;
    logic [PSUM_W:0]  psum_add;
    logic [TSUM_W:0]  tsum_add;
    logic [SQ_W:0]    psq_add, tsq_add;

    function automatic logic [LP_W-1:0] ptr_inc(input logic [LP_W-1:0] p);
        ptr_inc = (p == LP_W'(LIST_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SL_W-1:0] slot_inc(input logic [SL_W-1:0] p);
        slot_inc = (p == SL_W'(CLUSTER_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    ptcf_seq_acc #(.MAX_SEQ_LEN(MAX_SEQ_LEN)) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sample_en      (acc_sample_en),
        .flush_en       (acc_flush_en),
        .row            (s_data.row),
        .pad            (s_data.pad),
        .time_bin       (s_data.time_bin),
        .charge         (s_data.charge),
        .seq_end        (s_data.seq_end),
        .time_deconv_on (tdc_reg),
        .status         (acc_st),
        .split_snap     (split_snap),
        .end_snap       (end_snap)
    );

    ptcf_slot_mem #(.SLOTS(CLUSTER_SLOTS)) u_slots (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (slot_rd_en),
        .rd_addr   (slot_rd_addr),
        .rd_data   (slot_q),
        .wr_en     (slot_wr_en),
        .wr_addr   (slot_wr_addr),
        .wr_data   (slot_wr_data),
        .free_en   (slot_free_en),
        .free_addr (idx_reg),
        .clear_all (slot_clear),
        .busy      (busy)
    );

    ptcf_list_mem #(.DEPTH(LIST_DEPTH), .SLOT_W(SL_W)) u_list (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (lst_rd_en),
        .rd_addr   (lst_rd_addr),
        .rd_valid  (lst_q_valid),
        .rd_slot   (lst_q_slot),
        .wr_en     (lst_wr_en),
        .wr_addr   (lst_wr_addr),
        .wr_slot   (lst_wr_slot),
        .inv_en    (lst_inv_en),
        .inv_addr  (lst_inv_addr),
        .clear_all (lst_clear)
    );

    // merge test and updated slot words
    always_comb begin
        diff      = $signed({slot_q.mean[MEAN_W-1], slot_q.mean})
                  - $signed({cur_reg.mean[MEAN_W-1], cur_reg.mean});
        mw_s      = $signed((MEAN_W+1)'(mw_reg));
        too_late  = diff > mw_s;
        too_early = diff < -mw_s;
        rising    = CHG_W'(cur_reg.tc) > slot_q.last_charge;
        refuse    = pdc_reg && rising && slot_q.falling;
        merge_go  = (state_reg == ST_WALK_S) && !too_late && !too_early && !refuse;
        qual      = (slot_q.merges >= minm_reg) && (slot_q.charge >= thr_reg);

        chg_add  = (CHG_W+1)'(slot_q.charge) + (CHG_W+1)'(cur_reg.tc);
        psum_add = (PSUM_W+1)'(slot_q.pad_sum) + (PSUM_W+1)'(pprod_reg);
        tsum_add = (TSUM_W+1)'(slot_q.time_sum) + (TSUM_W+1)'(cur_reg.mt);
        psq_add  = (SQ_W+1)'(slot_q.pad_sq_sum) + (SQ_W+1)'(psq_reg);
        tsq_add  = (SQ_W+1)'(slot_q.time_sq_sum) + (SQ_W+1)'(cur_reg.st);

        merged_slot             = slot_q;
        merged_slot.mean        = cur_reg.mean;
        merged_slot.charge      = chg_add[CHG_W] ? '1 : chg_add[CHG_W-1:0];
        merged_slot.pad_sum     = psum_add[PSUM_W] ? '1 : psum_add[PSUM_W-1:0];
        merged_slot.time_sum    = tsum_add[TSUM_W] ? '1 : tsum_add[TSUM_W-1:0];
        merged_slot.pad_sq_sum  = psq_add[SQ_W] ? '1 : psq_add[SQ_W-1:0];
        merged_slot.time_sq_sum = tsq_add[SQ_W] ? '1 : tsq_add[SQ_W-1:0];
        merged_slot.merges      = (slot_q.merges == '1) ? slot_q.merges
                                                        : slot_q.merges + 1'b1;
        if (pdc_reg) begin
            merged_slot.last_charge = CHG_W'(cur_reg.tc);
            merged_slot.falling     = slot_q.falling | !rising;
        end

        ins_slot             = '0;
        ins_slot.row         = cur_reg.row;
        ins_slot.charge      = CHG_W'(cur_reg.tc);
        ins_slot.mean        = cur_reg.mean;
        ins_slot.last_charge = pdc_reg ? CHG_W'(cur_reg.tc) : '0;
        ins_slot.pad_sum     = PSUM_W'(pprod_reg);
        ins_slot.time_sum    = TSUM_W'(cur_reg.mt);
        ins_slot.pad_sq_sum  = SQ_W'(psq_reg);
        ins_slot.time_sq_sum = SQ_W'(cur_reg.st);
    end

    // result items
    always_comb begin
        cluster_item              = '0;
        cluster_item.kind         = KIND_CLUSTER;
        cluster_item.cluster_row  = slot_q.row;
        cluster_item.total_charge = slot_q.charge;
        cluster_item.pad_sum      = slot_q.pad_sum;
        cluster_item.time_sum     = slot_q.time_sum;
        cluster_item.pad_sq_sum   = slot_q.pad_sq_sum;
        cluster_item.time_sq_sum  = slot_q.time_sq_sum;
        cluster_item.merge_count  = slot_q.merges;
        marker_item               = '0;
        marker_item.kind          = KIND_END;
        marker_item.cluster_count = count_reg;
        out_free = !out_v_reg || m_ready;
        can_emit = !pend_v_reg || out_free;
    end

    // memory commands
    always_comb begin
        in_acc        = s_valid && s_ready;
        acc_sample_en = in_acc && (s_data.mode == MODE_SAMPLE);
        acc_flush_en  = in_acc && (s_data.mode == MODE_EVENT_END);

        slot_rd_en   = ((state_reg == ST_WALK_L) || (state_reg == ST_OUT_L)) && lst_q_valid;
        slot_rd_addr = lst_q_slot;
        slot_wr_en   = merge_go || ((state_reg == ST_INS) && !busy[cand_reg]);
        slot_wr_addr = (state_reg == ST_INS) ? cand_reg : idx_reg;
        slot_wr_data = (state_reg == ST_INS) ? ins_slot : merged_slot;
        slot_free_en = (state_reg == ST_OUT_S) && (!qual || can_emit);
        slot_clear   = (state_reg == ST_EV_CLR);

        lst_rd_en    = ((state_reg == ST_WALK) && (rp_reg != ep_reg))
                    || ((state_reg == ST_OSTEP) && (op_reg != fp_reg));
        lst_rd_addr  = (state_reg == ST_WALK) ? rp_reg : op_reg;
        lst_wr_en    = slot_wr_en;
        lst_wr_addr  = wp_reg;
        lst_wr_slot  = slot_wr_addr;
        lst_inv_en   = merge_go || (state_reg == ST_OUT_L);
        lst_inv_addr = (state_reg == ST_OUT_L) ? op_reg : rp_reg;
        lst_clear    = (state_reg == ST_EV_CLR);
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mw_reg   <= 8'd4;
            thr_reg  <= CHG_W'(10);
            minm_reg <= MRG_W'(1);
            tdc_reg  <= 1'b1;
            pdc_reg  <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MATCH_WINDOW: mw_reg   <= cfg_data[7:0];
                CFG_CHARGE_THR:   thr_reg  <= cfg_data[CHG_W-1:0];
                CFG_MIN_MERGES:   minm_reg <= cfg_data[MRG_W-1:0];
                CFG_TIME_DECONV:  tdc_reg  <= cfg_data[0];
                CFG_PAD_DECONV:   pdc_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // controller
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ev_reg       <= 1'b0;
            split_p_reg  <= 1'b0;
            fin_p_reg    <= 1'b0;
            step_out_reg <= 1'b0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            ep_reg       <= '0;
            fp_reg       <= '0;
            op_reg       <= '0;
            alloc_reg    <= '0;
            prev_row_reg <= '0;
            prev_pad_reg <= '0;
            count_reg    <= '0;
            pend_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
        end else begin
            if (m_ready) begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        ev_reg    <= (s_data.mode == MODE_EVENT_END);
                        state_reg <= ST_ACC_WAIT;
                    end
                end
                ST_ACC_WAIT: begin
                    if (acc_st.done) begin
                        split_p_reg <= acc_st.split;
                        fin_p_reg   <= acc_st.fin;
                        state_reg   <= ST_PICK;
                    end
                end
                // next sequence to place, split part first
                ST_PICK: begin
                    if (split_p_reg) begin
                        cur_reg      <= split_snap;
                        step_out_reg <= 1'b1;
                        split_p_reg  <= 1'b0;
                        state_reg    <= ST_MUL1;
                    end else if (fin_p_reg) begin
                        cur_reg      <= end_snap;
                        step_out_reg <= !ev_reg;
                        fin_p_reg    <= 1'b0;
                        state_reg    <= ST_MUL1;
                    end else if (ev_reg) begin
                        fp_reg    <= wp_reg;
                        rp_reg    <= wp_reg;
                        ep_reg    <= wp_reg;
                        state_reg <= ST_EV_DRAIN;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_MUL1: begin
                    pprod_reg <= PP_W'(cur_reg.tc) * PP_W'(cur_reg.pad);
                    padsq_reg <= PADSQ_W'(cur_reg.pad) * PADSQ_W'(cur_reg.pad);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    psq_reg   <= PSQ_W'(cur_reg.tc) * PSQ_W'(padsq_reg);
                    state_reg <= ST_PSTART;
                end
                // window of the previous pad, full-list check
                ST_PSTART: begin
                    if (cur_reg.tc == '0) begin
                        state_reg <= step_out_reg ? ST_OSTEP : ST_PICK;
                    end else begin
                        if (cur_reg.row != prev_row_reg) begin
                            fp_reg <= wp_reg;
                            rp_reg <= wp_reg;
                            ep_reg <= wp_reg;
                        end else if ((PAD_W+1)'(cur_reg.pad)
                                     == (PAD_W+1)'(prev_pad_reg) + 1'b1) begin
                            rp_reg <= ep_reg;
                            ep_reg <= wp_reg;
                        end else if (cur_reg.pad != prev_pad_reg) begin
                            fp_reg <= wp_reg;
                            rp_reg <= wp_reg;
                            ep_reg <= wp_reg;
                        end
                        prev_row_reg <= cur_reg.row;
                        prev_pad_reg <= cur_reg.pad;
                        if (ptr_inc(wp_reg) == op_reg) begin
                            state_reg <= step_out_reg ? ST_OSTEP : ST_PICK;
                        end else begin
                            state_reg <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    if (rp_reg == ep_reg) begin
                        cand_reg  <= slot_inc(alloc_reg);
                        cnt_reg   <= '0;
                        state_reg <= ST_INS;
                    end else begin
                        state_reg <= ST_WALK_L;
                    end
                end
                ST_WALK_L: begin
                    idx_reg <= lst_q_slot;
                    if (!lst_q_valid) begin
                        rp_reg    <= ptr_inc(rp_reg);
                        state_reg <= ST_WALK;
                    end else begin
                        state_reg <= ST_WALK_S;
                    end
                end
                // compare mean times: merge, move on or open a new cluster
                ST_WALK_S: begin
                    if (too_late) begin
                        rp_reg    <= ptr_inc(rp_reg);
                        state_reg <= ST_WALK;
                    end else if (too_early) begin
                        cand_reg  <= slot_inc(alloc_reg);
                        cnt_reg   <= '0;
                        state_reg <= ST_INS;
                    end else if (refuse) begin
                        rp_reg    <= ptr_inc(rp_reg);
                        cand_reg  <= slot_inc(alloc_reg);
                        cnt_reg   <= '0;
                        state_reg <= ST_INS;
                    end else begin
                        rp_reg    <= ptr_inc(rp_reg);
                        wp_reg    <= ptr_inc(wp_reg);
                        state_reg <= step_out_reg ? ST_OSTEP : ST_PICK;
                    end
                end
                // free slot scan, one candidate a cycle
                ST_INS: begin
                    if (!busy[cand_reg]) begin
                        alloc_reg <= cand_reg;
                        wp_reg    <= ptr_inc(wp_reg);
                        state_reg <= step_out_reg ? ST_OSTEP : ST_PICK;
                    end else if (cnt_reg == SL_W'(CLUSTER_SLOTS - 1)) begin
                        state_reg <= step_out_reg ? ST_OSTEP : ST_PICK;
                    end else begin
                        cand_reg <= slot_inc(cand_reg);
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                // retire one list entry
                ST_OSTEP: begin
                    if (op_reg == fp_reg) begin
                        state_reg <= ev_reg ? ST_EV_DRAIN : ST_PICK;
                    end else begin
                        state_reg <= ST_OUT_L;
                    end
                end
                ST_OUT_L: begin
                    idx_reg <= lst_q_slot;
                    op_reg  <= ptr_inc(op_reg);
                    if (!lst_q_valid) begin
                        state_reg <= ev_reg ? ST_EV_DRAIN : ST_PICK;
                    end else begin
                        state_reg <= ST_OUT_S;
                    end
                end
                ST_OUT_S: begin
                    if (!qual) begin
                        state_reg <= ev_reg ? ST_EV_DRAIN : ST_PICK;
                    end else if (can_emit) begin
                        if (pend_v_reg) begin
                            out_reg      <= pend_reg;
                            out_reg.last <= 1'b0;
                            out_v_reg    <= 1'b1;
                        end
                        pend_reg   <= cluster_item;
                        pend_v_reg <= 1'b1;
                        if (count_reg != '1) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= ev_reg ? ST_EV_DRAIN : ST_PICK;
                    end
                end
                ST_EV_DRAIN: begin
                    state_reg <= (op_reg == fp_reg) ? ST_EV_MARK : ST_OSTEP;
                end
                ST_EV_MARK: begin
                    if (can_emit) begin
                        if (pend_v_reg) begin
                            out_reg      <= pend_reg;
                            out_reg.last <= 1'b0;
                            out_v_reg    <= 1'b1;
                        end
                        pend_reg   <= marker_item;
                        pend_v_reg <= 1'b1;
                        state_reg  <= ST_EV_CLR;
                    end
                end
                // back to the reset picture, registers kept
                ST_EV_CLR: begin
                    wp_reg       <= '0;
                    rp_reg       <= '0;
                    ep_reg       <= '0;
                    fp_reg       <= '0;
                    op_reg       <= '0;
                    alloc_reg    <= '0;
                    prev_row_reg <= '0;
                    prev_pad_reg <= '0;
                    count_reg    <= '0;
                    state_reg    <= ST_FINISH;
                end
                // the staged item is the last of this input item
                ST_FINISH: begin
                    if (!pend_v_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (out_free) begin
                        out_reg      <= pend_reg;
                        out_reg.last <= 1'b1;
                        out_v_reg    <= 1'b1;
                        pend_v_reg   <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_v_reg;
    assign m_data    = out_reg;

    // slot memory is never read and written in the same cycle
    a_slot_rw_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(slot_rd_en && slot_wr_en))
        else $error("slot memory read and write overlap");

    // a new cluster only lands in a free slot
    a_ins_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_wr_en && state_reg == ST_INS) |-> !busy[cand_reg])
        else $error("insert into a busy slot");

    // nothing stays staged once the block is idle again
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_v_reg)
        else $error("staged result left behind");

    // the sequence unit reports only while the controller waits for it
    a_acc_done: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_st.done |-> (state_reg == ST_ACC_WAIT))
        else $error("sequence result while controller busy");

    // an accepted item always leaves the idle state
    a_accept_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> (state_reg == ST_ACC_WAIT))
        else $error("accepted item not started");

endmodule

`default_nettype wire
